/* hdl/sst_pkg.sv */
// Shared constants, codes and beat types of the scoped symbol table.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    localparam int MAX_LEVELS  = 16;
    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 64;

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int OPEN_W  = $clog2(MAX_LEVELS + 1);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W = KEY_BITS + LVL_W;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_COUNT  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_NO_SCOPE  = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [63:0] key;
    } t_cmd_beat;

    typedef struct packed {
        t_status    status;
        logic       found;
        logic [6:0] symbol_count;
    } t_res_beat;

endpackage

`default_nettype wire

/* hdl/sst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/scoped_symbol_table_top.sv */
// Top level of the scoped symbol table: command sequencer over the entry RAM.
//
// Usage: a command beat (command, key) is taken on a rising edge where start
// is high and busy is low. Each command returns exactly one result beat on
// o_result, marked by o_done for a single cycle; the receiver cannot stall it.
// Push, count query and unused codes answer in the cycle after acceptance,
// as do pop and insert when no scope is open. Lookup always, and pop and
// insert otherwise, walk every entry of the table: one RAM read per cycle
// in S_SCAN, then S_DRAIN, then S_DONE, which registers the result beat;
// busy stays high through the walk, and the next command may be accepted in
// the cycle the result is shown. The single-read-port entry RAM forces the walk.
// Keys and levels live in the RAM; valid bits, the open-scope depth and the
// live-symbol count live in flip-flops. A synchronous active-low reset clears
// the valid bits, closes all scopes and zeroes the count, so the block
// accepts commands right after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module scoped_symbol_table_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sst_pkg::t_cmd_beat i_cmd,
    output logic                   o_done,
    output sst_pkg::t_res_beat     o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                         r_state;
    sst_pkg::t_cmd                  r_op;
    logic [sst_pkg::KEY_BITS-1:0]   r_key;
    logic [sst_pkg::LVL_W-1:0]      r_top;
    logic [sst_pkg::IDX_W-1:0]      r_scan_idx;
    logic [sst_pkg::IDX_W-1:0]      r_rd_idx;
    logic                           r_rd_vld;
    logic                           r_dup;
    logic                           r_hit;
    logic                           r_have_free;
    logic [sst_pkg::IDX_W-1:0]      r_free;
    logic [sst_pkg::MAX_ENTRIES-1:0] r_valid;
    logic [sst_pkg::OPEN_W-1:0]     r_open;
    logic [sst_pkg::CNT_W-1:0]      r_count;
    logic                           r_done;
    sst_pkg::t_res_beat             r_result;

    logic                           w_we;
    logic [sst_pkg::ENTRY_W-1:0]    w_wdata;
    logic [sst_pkg::ENTRY_W-1:0]    w_rdata;
    logic [sst_pkg::KEY_BITS-1:0]   w_rd_key;
    logic [sst_pkg::LVL_W-1:0]      w_rd_lvl;
    logic                           w_rd_live;
    logic                           w_last;
    logic                           w_ins_ok;

    // Each RAM word holds the entry's level above its key.
    assign w_rd_key  = w_rdata[sst_pkg::KEY_BITS-1:0];
    assign w_rd_lvl  = w_rdata[sst_pkg::ENTRY_W-1:sst_pkg::KEY_BITS];
    assign w_rd_live = r_valid[r_rd_idx];
    assign w_last    = (r_scan_idx == sst_pkg::IDX_W'(sst_pkg::MAX_ENTRIES - 1));

    // An insert that survives the walk is written at the lowest free slot found.
    assign w_ins_ok = (r_op == sst_pkg::CMD_INSERT) && !r_dup && r_have_free;
    assign w_we     = (r_state == S_DONE) && w_ins_ok;
    assign w_wdata  = {r_top, r_key};

    sst_ram #(
        .WIDTH (sst_pkg::ENTRY_W),
        .DEPTH (sst_pkg::MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_free),
        .i_wdata (w_wdata),
        .i_raddr (r_scan_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_valid  <= '0;
            r_open   <= '0;
            r_count  <= '0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;

            // Evaluate the entry whose read was issued in the previous cycle.
            // Key and level are only trusted where the valid bit is set.
            if (r_rd_vld) begin
                case (r_op)
                    sst_pkg::CMD_POP: begin
                        if (w_rd_live && (w_rd_lvl == r_top)) begin
                            r_valid[r_rd_idx] <= 1'b0;
                            if (r_count != '0) begin
                                r_count <= r_count - 1'b1;
                            end
                        end
                    end
                    sst_pkg::CMD_INSERT: begin
                        if (w_rd_live) begin
                            if ((w_rd_lvl == r_top) && (w_rd_key == r_key)) begin
                                r_dup <= 1'b1;
                            end
                        end else if (!r_have_free) begin
                            r_have_free <= 1'b1;
                            r_free      <= r_rd_idx;
                        end
                    end
                    sst_pkg::CMD_LOOKUP: begin
                        if (w_rd_live && (sst_pkg::OPEN_W'(w_rd_lvl) < r_open)
                                && (w_rd_key == r_key)) begin
                            r_hit <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op        <= i_cmd.command;
                        r_key       <= sst_pkg::KEY_BITS'(i_cmd.key);
                        r_top       <= sst_pkg::LVL_W'(r_open - 1'b1);
                        r_scan_idx  <= '0;
                        r_dup       <= 1'b0;
                        r_hit       <= 1'b0;
                        r_have_free <= 1'b0;
                        r_free      <= '0;
                        r_result.status       <= sst_pkg::ST_OK;
                        r_result.found        <= 1'b0;
                        r_result.symbol_count <= 7'(r_count);
                        case (i_cmd.command)
                            sst_pkg::CMD_PUSH: begin
                                r_done <= 1'b1;
                                if (r_open >= sst_pkg::OPEN_W'(sst_pkg::MAX_LEVELS)) begin
                                    r_result.status <= sst_pkg::ST_OVERFLOW;
                                end else begin
                                    r_open <= r_open + 1'b1;
                                end
                            end
                            sst_pkg::CMD_POP: begin
                                if (r_open == '0) begin
                                    r_done          <= 1'b1;
                                    r_result.status <= sst_pkg::ST_UNDERFLOW;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            sst_pkg::CMD_INSERT: begin
                                if (r_open == '0) begin
                                    r_done          <= 1'b1;
                                    r_result.status <= sst_pkg::ST_NO_SCOPE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            sst_pkg::CMD_LOOKUP: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_scan_idx;
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state               <= S_IDLE;
                    r_done                <= 1'b1;
                    r_result.status       <= sst_pkg::ST_OK;
                    r_result.found        <= 1'b0;
                    r_result.symbol_count <= 7'(r_count);
                    case (r_op)
                        sst_pkg::CMD_POP: begin
                            r_open <= r_open - 1'b1;
                        end
                        sst_pkg::CMD_INSERT: begin
                            if (r_dup) begin
                                r_result.status <= sst_pkg::ST_DUPLICATE;
                            end else if (!r_have_free) begin
                                r_result.status <= sst_pkg::ST_FULL;
                            end else begin
                                r_valid[r_free]       <= 1'b1;
                                r_count               <= r_count + 1'b1;
                                r_result.symbol_count <= 7'(r_count + 1'b1);
                            end
                        end
                        sst_pkg::CMD_LOOKUP: begin
                            r_result.found <= r_hit;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* tb/sv/tb_scoped_symbol_table_top.sv */
// Self-checking testbench of the scoped symbol table with a scope-stack predictor.
`timescale 1ns / 1ps

module tb_scoped_symbol_table_top;

    import sst_pkg::*;

    // Run guard. The slowest legal run is roughly 830 commands, each with a
    // full table walk plus the longest sender gap; the limit leaves several
    // times that.
    localparam int CYCLE_LIMIT = 500000;
    // Commands 5 to 7 carry no name in the package; the block must treat them
    // as no-ops that still answer.
    localparam logic [2:0] FIRST_SPARE_CODE = 3'd5;
    localparam logic [2:0] LAST_SPARE_CODE  = 3'd7;
    localparam logic [63:0] ALL_ONES_KEY    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ZERO_KEY    = 64'h0;
    localparam logic [63:0] CHECKER_KEY     = 64'h5555_5555_5555_5555;
    localparam int KEY_POOL_SIZE = 16;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_cmd_beat i_cmd;
    logic      o_done;
    t_res_beat o_result;

    scoped_symbol_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Shadow copy of the symbol table. Slot key and level are only ever read
    // where the slot is live, just as in the block.
    logic [KEY_BITS-1:0] slot_key   [MAX_ENTRIES];
    int                  slot_level [MAX_ENTRIES];
    bit                  slot_live  [MAX_ENTRIES];
    int                  open_depth;
    int                  live_syms;

    // Answers predicted for accepted commands, oldest first.
    t_res_beat answer_q [$];

    int  bad_beats;
    int  cycle_count;
    // While set, the sender never inserts a gap between commands.
    bit  calm;
    logic [63:0] key_pool [KEY_POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout: a hung handshake or a lost result ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d answers outstanding", $time, answer_q.size());
            $display("[scoped_symbol_table_top] ERROR");
            $finish;
        end
    end

    // Predicts the answer to one command and advances the shadow table the
    // same way the block does. Error statuses leave the table untouched.
    function automatic t_res_beat table_answer(input logic [2:0] code,
                                               input logic [63:0] key);
        t_res_beat           ans;
        logic [KEY_BITS-1:0] k;
        bit                  dup;
        bit                  have_free;
        int                  free_idx;
        int                  top;
        k         = key[KEY_BITS-1:0];
        dup       = 1'b0;
        have_free = 1'b0;
        free_idx  = 0;
        top       = open_depth - 1;
        ans.status = ST_OK;
        ans.found  = 1'b0;
        case (code)
            CMD_PUSH: begin
                if (open_depth >= MAX_LEVELS)
                    ans.status = ST_OVERFLOW;
                else
                    open_depth++;
            end
            CMD_POP: begin
                if (open_depth == 0) begin
                    ans.status = ST_UNDERFLOW;
                end else begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (slot_live[i] && slot_level[i] == top) begin
                            slot_live[i] = 1'b0;
                            if (live_syms > 0)
                                live_syms--;
                        end
                    end
                    open_depth = top;
                end
            end
            CMD_INSERT: begin
                if (open_depth == 0) begin
                    ans.status = ST_NO_SCOPE;
                end else begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (slot_live[i]) begin
                            if (slot_level[i] == top && slot_key[i] == k)
                                dup = 1'b1;
                        end else if (!have_free) begin
                            have_free = 1'b1;
                            free_idx  = i;
                        end
                    end
                    // A duplicate is reported even when the table is full.
                    if (dup) begin
                        ans.status = ST_DUPLICATE;
                    end else if (!have_free) begin
                        ans.status = ST_FULL;
                    end else begin
                        slot_key[free_idx]   = k;
                        slot_level[free_idx] = top;
                        slot_live[free_idx]  = 1'b1;
                        live_syms++;
                    end
                end
            end
            CMD_LOOKUP: begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (slot_live[i] && slot_level[i] < open_depth && slot_key[i] == k)
                        ans.found = 1'b1;
                end
            end
            default: begin
                // Count query and the spare codes change nothing.
            end
        endcase
        ans.symbol_count = 7'(live_syms);
        return ans;
    endfunction

    // Sends one command beat. Start stays high after acceptance so that a
    // back-to-back command needs no second assignment in the same step; any
    // caller that lets time pass without a new command lowers it first.
    task automatic issue_cmd(input logic [2:0] code, input logic [63:0] key);
        int gap;
        if (!calm && $urandom_range(99) < 12) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(70, 1) : $urandom_range(8, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= t_cmd_beat'({code, key});
        // The beat is taken at the first edge that sees busy low.
        do @(posedge i_clk); while (busy);
        answer_q.push_back(table_answer(code, key));
    endtask

    // Holds the sender off until every predicted answer has been seen.
    task automatic wait_answers();
        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Result checker: the receiver cannot stall, so every cycle with o_done
    // high is one result beat, compared against the oldest prediction.
    always @(posedge i_clk) begin
        t_res_beat want;
        if (i_rst_n && o_done) begin
            if (answer_q.size() == 0) begin
                $display("%0t: result beat with no command outstanding: status %0d found %0d count %0d",
                         $time, o_result.status, o_result.found, o_result.symbol_count);
                bad_beats++;
            end else begin
                want = answer_q.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    bad_beats++;
                end
                if (o_result.found !== want.found) begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, o_result.found);
                    bad_beats++;
                end
                if (o_result.symbol_count !== want.symbol_count) begin
                    $display("%0t: symbol_count expected %0d actual %0d",
                             $time, want.symbol_count, o_result.symbol_count);
                    bad_beats++;
                end
            end
        end
    end

    // Pop, insert and lookup issued on an empty table with no scope open, plus
    // the count query and the spare codes.
    task automatic test_empty_table();
        issue_cmd(CMD_POP, ALL_ZERO_KEY);
        issue_cmd(CMD_INSERT, ALL_ONES_KEY);
        issue_cmd(CMD_LOOKUP, ALL_ONES_KEY);
        issue_cmd(CMD_COUNT, CHECKER_KEY);
        for (logic [3:0] c = {1'b0, FIRST_SPARE_CODE}; c <= {1'b0, LAST_SPARE_CODE}; c++)
            issue_cmd(c[2:0], ALL_ONES_KEY);
    endtask

    // Extreme keys, a duplicate in the same level, shadowing from an inner
    // level, and the outer entry reappearing once the inner level closes.
    task automatic test_shadowing();
        issue_cmd(CMD_PUSH, ALL_ZERO_KEY);
        issue_cmd(CMD_INSERT, ALL_ONES_KEY);
        issue_cmd(CMD_INSERT, ALL_ZERO_KEY);
        issue_cmd(CMD_INSERT, ALL_ONES_KEY);
        issue_cmd(CMD_LOOKUP, ALL_ONES_KEY);
        issue_cmd(CMD_LOOKUP, ALL_ZERO_KEY);
        issue_cmd(CMD_LOOKUP, CHECKER_KEY);
        issue_cmd(CMD_PUSH, ALL_ZERO_KEY);
        issue_cmd(CMD_INSERT, ALL_ONES_KEY);
        issue_cmd(CMD_LOOKUP, ALL_ONES_KEY);
        issue_cmd(CMD_POP, ALL_ZERO_KEY);
        issue_cmd(CMD_LOOKUP, ALL_ONES_KEY);
        issue_cmd(CMD_COUNT, ALL_ZERO_KEY);
        issue_cmd(CMD_POP, ALL_ZERO_KEY);
        issue_cmd(CMD_LOOKUP, ALL_ONES_KEY);
        issue_cmd(CMD_POP, ALL_ZERO_KEY);
    endtask

    // Opens every level, pushes once more, then unwinds past the bottom.
    task automatic test_scope_overflow();
        logic [63:0] k;
        k = {$urandom, $urandom};
        for (int i = 0; i < MAX_LEVELS; i++)
            issue_cmd(CMD_PUSH, ALL_ZERO_KEY);
        issue_cmd(CMD_PUSH, ALL_ONES_KEY);
        issue_cmd(CMD_INSERT, k);
        issue_cmd(CMD_LOOKUP, k);
        for (int i = 0; i <= MAX_LEVELS; i++)
            issue_cmd(CMD_POP, ALL_ZERO_KEY);
    endtask

    // Fills every slot, then checks that a duplicate still wins over a full
    // table and that a fresh inner level cannot take a symbol either.
    task automatic test_table_full();
        logic [63:0] first_key;
        first_key = {$urandom, 24'h0, 8'h0};
        issue_cmd(CMD_PUSH, ALL_ZERO_KEY);
        for (int i = 0; i < MAX_ENTRIES; i++)
            issue_cmd(CMD_INSERT, {first_key[63:8], 8'(i)});
        issue_cmd(CMD_INSERT, ALL_ONES_KEY);
        issue_cmd(CMD_INSERT, first_key);
        issue_cmd(CMD_LOOKUP, {first_key[63:8], 8'(MAX_ENTRIES - 1)});
        issue_cmd(CMD_PUSH, ALL_ZERO_KEY);
        issue_cmd(CMD_INSERT, ALL_ONES_KEY);
        issue_cmd(CMD_POP, ALL_ZERO_KEY);
        issue_cmd(CMD_POP, ALL_ZERO_KEY);
        issue_cmd(CMD_COUNT, ALL_ZERO_KEY);
    endtask

    // Mostly meaningful traffic: keys drawn from a small pool so that inserts
    // collide and lookups hit, with fully random keys and spare codes as noise.
    task automatic test_random_mix(input int n_items);
        int          r;
        logic [2:0]  code;
        logic [63:0] key;
        for (int i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < n_items; n++) begin
            // A long stretch with the sender never pausing.
            calm = (n >= n_items / 3) && (n < n_items / 3 + 150);
            // Once mid-run the sender waits for every answer to come back.
            if (n == (2 * n_items) / 3)
                wait_answers();
            r = $urandom_range(99);
            if (r < 14)
                code = CMD_PUSH;
            else if (r < 26)
                code = CMD_POP;
            else if (r < 62)
                code = CMD_INSERT;
            else if (r < 90)
                code = CMD_LOOKUP;
            else if (r < 95)
                code = CMD_COUNT;
            else
                code = 3'($urandom_range(32'(LAST_SPARE_CODE), 32'(FIRST_SPARE_CODE)));
            // With no scope open, most commands would only bounce off.
            if (open_depth == 0 && $urandom_range(3) != 0)
                code = CMD_PUSH;
            if ($urandom_range(9) < 7)
                key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            else
                key = {$urandom, $urandom};
            issue_cmd(code, key);
        end
        calm = 1'b0;
    endtask

    initial begin
        start       <= 1'b0;
        i_cmd       <= '0;
        i_rst_n     <= 1'b0;
        bad_beats   = 0;
        cycle_count = 0;
        calm        = 1'b0;
        open_depth  = 0;
        live_syms   = 0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            slot_live[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_shadowing();
        wait_answers();
        test_scope_overflow();
        test_table_full();
        wait_answers();
        test_random_mix(700);

        wait_answers();
        // Let any stray result of a full table walk show up before judging.
        repeat (MAX_ENTRIES + 8) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            $display("%0t: %0d answers never arrived", $time, answer_q.size());
            bad_beats++;
        end
        if (bad_beats == 0) begin
            $display("[scoped_symbol_table_top] OK");
        end else begin
            $display("[scoped_symbol_table_top] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/scoped_symbol_table_top.sv
tb/sv/tb_scoped_symbol_table_top.sv
